// ----- rtl/core/midi_timecode_and_clock_generator_defines.svh -----
// Assertion macros shared by the checker of the MIDI timecode and clock generator.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef MIDI_TIMECODE_AND_CLOCK_GENERATOR_DEFINES_SVH
`define MIDI_TIMECODE_AND_CLOCK_GENERATOR_DEFINES_SVH

// Check a property at every rising edge outside reset.
`define MTCG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define MTCG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/mtcg_pkg.sv -----
// Shared types and constants of the MIDI timecode and clock generator.
// No dependencies; imported by every module of the block but the divider.
`default_nettype none

package mtcg_pkg;

  // Widths of the configuration port and of the divider, and the default frame position width
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAME_BITS_DEF = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_BEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MTC_RATE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MTC_FPS         = 2'd3;

  // Sync mode codes
  localparam logic [1:0] SYNC_NONE  = 2'd0;
  localparam logic [1:0] SYNC_CLOCK = 2'd1;
  localparam logic [1:0] SYNC_MTC   = 2'd2;

  // Reset values of the registers
  localparam logic [1:0]       RST_SYNC_MODE       = SYNC_NONE;
  localparam logic [CFG_W-1:0] RST_FRAMES_PER_BEAT = 32'd44100;
  localparam logic [CFG_W-1:0] RST_MTC_RATE        = 32'd3528;
  localparam logic [4:0]       RST_MTC_FPS         = 5'd25;

  // Clock period is frames_per_beat / 24: shift right by 3, then divide by 3
  // as a multiply by the reciprocal 0xAAAAAAAB and a right shift by 33
  localparam int          CLOCK_DIV_SHIFT  = 3;
  localparam logic [31:0] CLOCK_DIV_RECIP  = 32'hAAAA_AAAB;
  localparam int          CLOCK_DIV_RSHIFT = 33;

  // Seconds and minutes wrap value
  localparam logic [5:0] SIXTY = 6'd60;

  // MIDI bytes
  localparam logic [7:0] MSG_CLOCK      = 8'hF8;
  localparam logic [7:0] MSG_QUARTER    = 8'hF1;
  localparam logic [7:0] MSG_SYSEX      = 8'hF0;
  localparam logic [7:0] MSG_EOX        = 8'hF7;
  localparam logic [6:0] SYX_REALTIME   = 7'h7F;
  localparam logic [6:0] SYX_DEVICE     = 7'h00;
  localparam logic [7:0] SYX_SUB_MTC    = 8'h01;
  localparam logic [6:0] SYX_FULL_FRAME = 7'h01;

  // Index of the last message of a four-message burst
  localparam logic [1:0] LAST_IDX = 2'd3;

  typedef enum logic {
    SEL_RATE,
    SEL_PERIOD
  } div_sel_e;

  typedef enum logic [1:0] {
    KIND_CLOCK,
    KIND_QF,
    KIND_SYSEX
  } msg_kind_e;

  typedef struct packed {
    logic      latch_in;
    logic      clear_tc;
    logic      div_start;
    div_sel_e  div_sel;
    logic      load_out;
    msg_kind_e kind;
    logic [1:0] idx;
    logic      last;
    logic      advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       cmd_rewind;
    logic [1:0] sync_mode;
    logic       div_done;
    logic       period_zero;
    logic       rem_zero;
    logic       rate_zero;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/mtcg_div.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle; only the
// remainder is brought out. Depends on nothing but its width parameter.
`default_nettype none

module mtcg_div #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] rem_o
);

  localparam int CntW = $clog2(W);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    ge      = ~diff[W+1];
    rem_d   = ge ? diff[W-1:0] : shifted[W-1:0];
    quo_d   = {quo_q[W-2:0], ge};
  end

  // Control: busy flag, step count and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands on start, one step per busy cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/mtcg_datapath.sv -----
// Datapath: configuration registers, input latch, divider, timecode counters
// and the output message register. Uses mtcg_pkg and mtcg_div.
`default_nettype none

module mtcg_datapath import mtcg_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 command_i,
  input  logic [31:0]          frame_pos_i,
  input  logic                 cfg_write_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output logic [7:0]           first_byte_o,
  output logic [6:0]           data1_o,
  output logic                 data1_present_o,
  output logic [6:0]           data2_o,
  output logic                 data2_present_o,
  output logic                 last_o
);

  localparam int PosW    = (FRAME_BITS < 32) ? FRAME_BITS : 32;
  localparam int ScaledW = CFG_W - CLOCK_DIV_SHIFT;

  // Configuration registers
  logic [1:0]       sync_mode_q;
  logic [CFG_W-1:0] fpb_q;
  logic [CFG_W-1:0] rate_q;
  logic [4:0]       fps_q;

  // Latched input item
  logic            rewind_q;
  logic [PosW-1:0] pos_q;

  // Timecode counters
  logic [4:0] fc_q, fc_d;
  logic [5:0] sec_q, sec_d;
  logic [5:0] min_q, min_d;
  logic [7:0] hr_q, hr_d;

  // Clock period from frames per beat
  logic [ScaledW-1:0]    fpb_scaled;
  logic [ScaledW+31:0]   period_prod;
  logic [CFG_W-1:0]      clk_period;

  // Divider operands and results
  logic [CFG_W-1:0] div_dividend;
  logic [CFG_W-1:0] div_divisor;
  logic             div_done;
  logic [CFG_W-1:0] div_rem;

  // Next message
  logic [7:0] msg_first;
  logic [6:0] msg_d1;
  logic       msg_d1p;
  logic [6:0] msg_d2;
  logic       msg_d2p;
  logic [3:0] qf_nibble;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_mode_q <= RST_SYNC_MODE;
      fpb_q       <= RST_FRAMES_PER_BEAT;
      rate_q      <= RST_MTC_RATE;
      fps_q       <= RST_MTC_FPS;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        REG_SYNC_MODE:       sync_mode_q <= cfg_data_i[1:0];
        REG_FRAMES_PER_BEAT: fpb_q       <= cfg_data_i;
        REG_MTC_RATE:        rate_q      <= cfg_data_i;
        REG_MTC_FPS:         fps_q       <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      rewind_q <= command_i;
      pos_q    <= frame_pos_i[PosW-1:0];
    end
  end

  // Advance the cascaded frame, second, minute and hour counters
  always_comb begin
    fc_d  = fc_q + 5'd1;
    sec_d = sec_q;
    min_d = min_q;
    hr_d  = hr_q;
    if (fc_d >= fps_q) begin
      fc_d  = '0;
      sec_d = sec_q + 6'd1;
      if (sec_d >= SIXTY) begin
        sec_d = '0;
        min_d = min_q + 6'd1;
        if (min_d >= SIXTY) begin
          min_d = '0;
          hr_d  = hr_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q  <= '0;
      sec_q <= '0;
      min_q <= '0;
      hr_q  <= '0;
    end else if (cmd_i.clear_tc) begin
      fc_q  <= '0;
      sec_q <= '0;
      min_q <= '0;
      hr_q  <= '0;
    end else if (cmd_i.advance) begin
      fc_q  <= fc_d;
      sec_q <= sec_d;
      min_q <= min_d;
      hr_q  <= hr_d;
    end
  end

  // Divide frames per beat by 24: drop three bits, then multiply by 1/3
  always_comb begin
    fpb_scaled  = fpb_q[CFG_W-1:CLOCK_DIV_SHIFT];
    period_prod = fpb_scaled * CLOCK_DIV_RECIP;
    clk_period  = CFG_W'(period_prod >> CLOCK_DIV_RSHIFT);
  end

  // Pick divider operands: position by clock period or by timecode rate
  always_comb begin
    div_dividend = CFG_W'(pos_q);
    case (cmd_i.div_sel)
      SEL_PERIOD: div_divisor = clk_period;
      default:    div_divisor = rate_q;
    endcase
  end

  mtcg_div #(
    .W (CFG_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Nibble of a quarter-frame piece; odd frames carry minutes and hours
  always_comb begin
    case ({fc_q[0], cmd_i.idx})
      3'd0:    qf_nibble = fc_q[3:0];
      3'd1:    qf_nibble = {3'b000, fc_q[4]};
      3'd2:    qf_nibble = sec_q[3:0];
      3'd3:    qf_nibble = {2'b00, sec_q[5:4]};
      3'd4:    qf_nibble = min_q[3:0];
      3'd5:    qf_nibble = {2'b00, min_q[5:4]};
      3'd6:    qf_nibble = hr_q[3:0];
      default: qf_nibble = hr_q[7:4];
    endcase
  end

  // Build the message selected by kind and index
  always_comb begin
    msg_first = MSG_CLOCK;
    msg_d1    = '0;
    msg_d1p   = 1'b0;
    msg_d2    = '0;
    msg_d2p   = 1'b0;
    case (cmd_i.kind)
      KIND_QF: begin
        msg_first = MSG_QUARTER;
        msg_d1    = {fc_q[0], cmd_i.idx, qf_nibble};
        msg_d1p   = 1'b1;
      end
      KIND_SYSEX: begin
        // full-frame sysex at time zero, three body pieces then end of exclusive
        case (cmd_i.idx)
          2'd0: begin
            msg_first = MSG_SYSEX;
            msg_d1    = SYX_REALTIME;
            msg_d1p   = 1'b1;
            msg_d2    = SYX_DEVICE;
            msg_d2p   = 1'b1;
          end
          2'd1: begin
            msg_first = SYX_SUB_MTC;
            msg_d1    = SYX_FULL_FRAME;
            msg_d1p   = 1'b1;
            msg_d2p   = 1'b1;
          end
          2'd2: begin
            msg_first = 8'h00;
            msg_d1p   = 1'b1;
            msg_d2p   = 1'b1;
          end
          default: msg_first = MSG_EOX;
        endcase
      end
      default: ;
    endcase
  end

  // Output message register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      first_byte_o    <= msg_first;
      data1_o         <= msg_d1;
      data1_present_o <= msg_d1p;
      data2_o         <= msg_d2;
      data2_present_o <= msg_d2p;
      last_o          <= cmd_i.last;
    end
  end

  // Status back to the controller
  always_comb begin
    status_o.cmd_rewind  = rewind_q;
    status_o.sync_mode   = sync_mode_q;
    status_o.div_done    = div_done;
    status_o.period_zero = (clk_period == '0);
    status_o.rem_zero    = (div_rem == '0);
    status_o.rate_zero   = (rate_q == '0);
  end

endmodule

`default_nettype wire

// ----- rtl/core/mtcg_ctrl.sv -----
// Controller state machine: decodes the item, sequences the divider and
// steps through the result messages. Uses mtcg_pkg.
`default_nettype none

module mtcg_ctrl import mtcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_MOD    = 5'b00100,
    ST_LOAD   = 5'b01000,
    ST_SHOW   = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  msg_kind_e  kind_q, kind_d;
  logic [1:0] idx_q, idx_d;
  logic       last;

  assign last = (kind_q == KIND_CLOCK) || (idx_q == LAST_IDX);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    idx_d   = idx_q;

    cmd_o           = '0;
    cmd_o.div_sel   = SEL_RATE;
    cmd_o.kind      = kind_q;
    cmd_o.idx       = idx_q;
    cmd_o.last      = last;

    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end

      // Route by command and sync mode
      ST_DECODE: begin
        idx_d = '0;
        if (status_i.cmd_rewind) begin
          cmd_o.clear_tc = 1'b1;
          kind_d         = KIND_SYSEX;
          state_d        = (status_i.sync_mode == SYNC_MTC) ? ST_LOAD : ST_IDLE;
        end else if (status_i.sync_mode == SYNC_CLOCK) begin
          kind_d = KIND_CLOCK;
          // A zero clock period fires on every tick
          if (status_i.period_zero) begin
            state_d = ST_LOAD;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = SEL_PERIOD;
            state_d         = ST_MOD;
          end
        end else if (status_i.sync_mode == SYNC_MTC) begin
          kind_d = KIND_QF;
          if (status_i.rate_zero) begin
            state_d = ST_LOAD;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = SEL_RATE;
            state_d         = ST_MOD;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      // Wait for position modulo period or rate; emit only on a multiple
      ST_MOD: begin
        if (status_i.div_done) begin
          state_d = status_i.rem_zero ? ST_LOAD : ST_IDLE;
        end
      end

      ST_LOAD: begin
        cmd_o.load_out = 1'b1;
        state_d        = ST_SHOW;
      end

      // Present the message; advance counters after the last quarter frame
      ST_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last) begin
            cmd_o.advance = (kind_q == KIND_QF);
            state_d       = ST_IDLE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = ST_LOAD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_CLOCK;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/midi_timecode_and_clock_generator.sv -----
// MIDI timecode and clock generator, top level.
// Input channel: one transfer carries a command (tick or rewind) and a frame
//   position; in_ready_o is high only while the block is idle.
// Output channel: zero to four messages per input, each a first byte with
//   optional data bytes; last_o marks the final message of an input.
// Config channel: always ready; write only while idle. Indexes 0..3 are
//   sync_mode, frames_per_beat, mtc_rate, mtc_fps.
// Timing: one item at a time. A 32-step shift-subtract divider (one bit per
//   cycle) finds position modulo period or rate; a tick on a multiple goes
//   on to its messages, any other tick frees the input with none. A zero
//   period or rate, and a rewind, skip the divider. Each message is loaded
//   into the output register, then shown until it is taken.
// Reset: registers take their defaults, counters clear, no output pending.
// Stall: a message holds on the ports until out_ready_i is seen high; the
//   input stays blocked until the last message of the item transfers.
`default_nettype none

module midi_timecode_and_clock_generator import mtcg_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [31:0]          frame_pos_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           first_byte_o,
  output logic [6:0]           data1_o,
  output logic                 data1_present_o,
  output logic [6:0]           data2_o,
  output logic                 data2_present_o,
  output logic                 last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration writes are taken in any cycle
  assign cfg_ready_o = 1'b1;

  mtcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mtcg_datapath #(
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .command_i       (command_i),
    .frame_pos_i     (frame_pos_i),
    .cfg_write_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .first_byte_o    (first_byte_o),
    .data1_o         (data1_o),
    .data1_present_o (data1_present_o),
    .data2_o         (data2_o),
    .data2_present_o (data2_present_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mtcg_checker.sv -----
// Port-level checker of the MIDI timecode and clock generator, bound to the top.
// Uses the assertion macros of midi_timecode_and_clock_generator_defines.svh.
`default_nettype none
`include "midi_timecode_and_clock_generator_defines.svh"

module mtcg_checker import mtcg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [31:0]          frame_pos_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic [7:0]           first_byte_o,
  input  logic [6:0]           data1_o,
  input  logic                 data1_present_o,
  input  logic [6:0]           data2_o,
  input  logic                 data2_present_o,
  input  logic                 last_o
);

  // Stalled result holds
  `MTCG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_byte_o) && $stable(last_o), "stalled result changed")

  // Never take an input while a result is shown
  `MTCG_ASSERT_ALWAYS(a_one_side, !(in_ready_o && out_valid_o), "input ready while result pending")

  // Block goes busy after an input transfer
  `MTCG_ASSERT(a_busy_after_in, in_valid_i && in_ready_o |=> !in_ready_o, "ready right after input transfer")

  // More results follow a transfer without last
  `MTCG_ASSERT(a_more_results, out_valid_o && out_ready_i && !last_o |=> !in_ready_o, "input freed before last result")

  // Absent data bytes read as zero
  `MTCG_ASSERT(a_absent_zero, out_valid_o |-> (data1_present_o || data1_o == 7'd0) && (data2_present_o || data2_o == 7'd0), "absent data byte not zero")

endmodule

bind midi_timecode_and_clock_generator mtcg_checker u_mtcg_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for midi_timecode_and_clock_generator: directed and random ticks and rewinds
// checked against an in-bench timecode and clock predictor. Depends on mtcg_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import mtcg_pkg::*;

  localparam logic       CMD_TICK        = 1'b0;
  localparam logic       CMD_REWIND      = 1'b1;
  localparam logic [1:0] SYNC_UNUSED     = 2'd3;
  localparam int         CLOCKS_PER_BEAT = 24;
  localparam int         SETTLE_CYCLES   = 100;
  localparam int         LONG_HOLD       = 400;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         NUM_CHUNKS      = 9;

  typedef struct packed {
    logic        cmd;
    logic [31:0] pos;
  } sync_item_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [6:0] data1;
    logic       data1_present;
    logic [6:0] data2;
    logic       data2_present;
    logic       last;
  } midi_msg_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 command_i = CMD_TICK;
  logic [31:0]          frame_pos_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_SYNC_MODE;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           first_byte_o;
  logic [6:0]           data1_o;
  logic                 data1_present_o;
  logic [6:0]           data2_o;
  logic                 data2_present_o;
  logic                 last_o;

  // Register copies and timecode counters of the predictor
  logic [1:0]  cfg_sync;
  logic [31:0] cfg_fpb;
  logic [31:0] cfg_rate;
  logic [4:0]  cfg_fps;
  logic [4:0]  tc_frame;
  logic [5:0]  tc_sec;
  logic [5:0]  tc_min;
  logic [7:0]  tc_hr;

  sync_item_t pending_items[$];
  midi_msg_t  midi_expected[$];

  int   send_idle_pct = 11;
  int   recv_idle_pct = 62;
  logic long_hold_req = 1'b0;
  int   mismatches = 0;
  int   msgs_checked = 0;
  int   inputs_accepted = 0;
  int   rewinds_seen = 0;
  int   clock_bytes = 0;
  int   qf_bursts = 0;
  int   reg_writes = 0;

  midi_timecode_and_clock_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .frame_pos_i     (frame_pos_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .first_byte_o    (first_byte_o),
    .data1_o         (data1_o),
    .data1_present_o (data1_present_o),
    .data2_o         (data2_o),
    .data2_present_o (data2_present_o),
    .last_o          (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic midi_msg_t make_msg(logic [7:0] b0, logic has1, logic [6:0] d1,
                                         logic has2, logic [6:0] d2, logic is_last);
    midi_msg_t m;
    m.first_byte    = b0;
    m.data1         = has1 ? d1 : 7'd0;
    m.data1_present = has1;
    m.data2         = has2 ? d2 : 7'd0;
    m.data2_present = has2;
    m.last          = is_last;
    return m;
  endfunction

  // Step the frame, second, minute and hour counters after a quarter-frame burst
  function automatic void advance_timecode();
    tc_frame = tc_frame + 5'd1;
    if (tc_frame >= cfg_fps) begin
      tc_frame = '0;
      tc_sec   = tc_sec + 6'd1;
      if (tc_sec >= SIXTY) begin
        tc_sec = '0;
        tc_min = tc_min + 6'd1;
        if (tc_min >= SIXTY) begin
          tc_min = '0;
          tc_hr  = tc_hr + 8'd1;
        end
      end
    end
  endfunction

  // Work out the MIDI messages one accepted input causes
  function automatic void predict_sync(logic cmd, logic [31:0] pos);
    logic [3:0]  nib [4];
    logic [31:0] period;
    logic        odd;
    if (cmd == CMD_REWIND) begin
      rewinds_seen++;
      tc_frame = '0;
      tc_sec   = '0;
      tc_min   = '0;
      tc_hr    = '0;
      if (cfg_sync == SYNC_MTC) begin
        midi_expected.push_back(make_msg(MSG_SYSEX, 1'b1, SYX_REALTIME, 1'b1, SYX_DEVICE, 1'b0));
        midi_expected.push_back(make_msg(SYX_SUB_MTC, 1'b1, SYX_FULL_FRAME, 1'b1, tc_hr[6:0],
                                         1'b0));
        midi_expected.push_back(make_msg({2'b00, tc_min}, 1'b1, {1'b0, tc_sec}, 1'b1,
                                         {2'b00, tc_frame}, 1'b0));
        midi_expected.push_back(make_msg(MSG_EOX, 1'b0, '0, 1'b0, '0, 1'b1));
      end
    end else if (cfg_sync == SYNC_CLOCK) begin
      period = cfg_fpb / CLOCKS_PER_BEAT;
      if (period == 0 || pos % period == 0) begin
        clock_bytes++;
        midi_expected.push_back(make_msg(MSG_CLOCK, 1'b0, '0, 1'b0, '0, 1'b1));
      end
    end else if (cfg_sync == SYNC_MTC) begin
      if (cfg_rate == 0 || pos % cfg_rate == 0) begin
        qf_bursts++;
        odd = tc_frame[0];
        if (!odd) begin
          nib[0] = tc_frame[3:0];
          nib[1] = {3'b000, tc_frame[4]};
          nib[2] = tc_sec[3:0];
          nib[3] = {2'b00, tc_sec[5:4]};
        end else begin
          nib[0] = tc_min[3:0];
          nib[1] = {2'b00, tc_min[5:4]};
          nib[2] = tc_hr[3:0];
          nib[3] = tc_hr[7:4];
        end
        // Piece number sits above the nibble: 0..3 on even frames, 4..7 on odd
        for (int p = 0; p < 4; p++) begin
          midi_expected.push_back(make_msg(MSG_QUARTER, 1'b1, {odd, 2'(p), nib[p]}, 1'b0, '0,
                                           p == 3));
        end
        advance_timecode();
      end
    end
  endfunction

  // Sender: predict on each transfer, then offer the next pending item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        inputs_accepted++;
        predict_sync(command_i, frame_pos_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          command_i   <= pending_items[0].cmd;
          frame_pos_i <= pending_items[0].pos;
          pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: check each message transfer, then stall at random or for a long hold
  int  hold_left = 0;
  bit  hold_taken = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    midi_msg_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        msgs_checked++;
        if (midi_expected.size() == 0) begin
          $error("unexpected message: first_byte %h data1 %h data2 %h last %b",
                 first_byte_o, data1_o, data2_o, last_o);
          mismatches++;
        end else begin
          want = midi_expected.pop_front();
          check_field("first_byte", want.first_byte, first_byte_o);
          check_field("data1", want.data1, data1_o);
          check_field("data1_present", want.data1_present, data1_present_o);
          check_field("data2", want.data2, data2_o);
          check_field("data2_present", want.data2_present, data2_present_o);
          check_field("last", want.last, last_o);
        end
      end
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d messages still expected", cycle_count,
             midi_expected.size());
    $display("midi_timecode_and_clock_generator verification failed");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      REG_SYNC_MODE:       cfg_sync = val[1:0];
      REG_FRAMES_PER_BEAT: cfg_fpb  = val;
      REG_MTC_RATE:        cfg_rate = val;
      REG_MTC_FPS:         cfg_fps  = val[4:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic void offer(logic cmd, logic [31:0] pos);
    sync_item_t it;
    it.cmd = cmd;
    it.pos = pos;
    pending_items.push_back(it);
  endfunction

  // Mostly ticks on a multiple of the active period, some off-grid ticks and rewinds
  function automatic void offer_random(int rewind_pct);
    logic [31:0] step;
    int          roll;
    step = (cfg_sync == SYNC_CLOCK) ? cfg_fpb / CLOCKS_PER_BEAT : cfg_rate;
    roll = $urandom_range(99);
    if (roll < rewind_pct)
      offer(CMD_REWIND, $urandom);
    else if (roll < rewind_pct + 10 || step == 0)
      offer(CMD_TICK, $urandom);
    else
      offer(CMD_TICK, step * $urandom_range(0, 32'hFFFF_FFFF / step));
  endfunction

  // Hold off until every item is in, every message is out and the block is idle
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || midi_expected.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
  endtask

  initial begin
    int n_items;
    int rewind_pct;
    cfg_sync = RST_SYNC_MODE;
    cfg_fpb  = RST_FRAMES_PER_BEAT;
    cfg_rate = RST_MTC_RATE;
    cfg_fps  = RST_MTC_FPS;
    tc_frame = '0;
    tc_sec   = '0;
    tc_min   = '0;
    tc_hr    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values: sync off, so nothing comes out
    offer(CMD_TICK, 32'd0);
    offer(CMD_REWIND, 32'hFFFF_FFFF);
    wait_idle();
    // Default clock period 44100 / 24
    write_reg(REG_SYNC_MODE, SYNC_CLOCK);
    offer(CMD_TICK, 32'd5511);
    offer(CMD_TICK, 32'd1838);
    wait_idle();
    // Default timecode rate 3528, then a full-frame rewind
    write_reg(REG_SYNC_MODE, SYNC_MTC);
    offer(CMD_TICK, 32'd7056);
    offer(CMD_TICK, 32'd3529);
    offer(CMD_REWIND, 32'd0);
    wait_idle();
    // Zero rate bursts on every tick; zero fps wraps the frame each burst
    write_reg(REG_MTC_RATE, 32'd0);
    write_reg(REG_MTC_FPS, 32'd0);
    offer(CMD_TICK, 32'hFFFF_FFFF);
    offer(CMD_TICK, 32'd0);
    offer(CMD_TICK, 32'h0001_2345);
    wait_idle();
    // Rate of 2, fps beyond range: odd frames show minutes and hours
    write_reg(REG_MTC_RATE, 32'd2);
    write_reg(REG_MTC_FPS, 32'd31);
    offer(CMD_TICK, 32'd1);
    offer(CMD_TICK, 32'hFFFF_FFFE);
    offer(CMD_TICK, 32'd0);
    offer(CMD_REWIND, 32'h8000_0001);
    offer(CMD_TICK, 32'd2);
    wait_idle();
    // Largest rate
    write_reg(REG_MTC_RATE, 32'hFFFF_FFFF);
    write_reg(REG_MTC_FPS, 32'd24);
    offer(CMD_TICK, 32'd0);
    offer(CMD_TICK, 32'hFFFF_FFFF);
    offer(CMD_TICK, 32'hFFFF_FFFE);
    wait_idle();
    // Clock period of zero fires on every tick; rewind in clock mode stays silent
    write_reg(REG_SYNC_MODE, SYNC_CLOCK);
    write_reg(REG_FRAMES_PER_BEAT, 32'd5);
    offer(CMD_TICK, 32'h5A5A_5A5A);
    offer(CMD_REWIND, 32'd0);
    wait_idle();
    write_reg(REG_FRAMES_PER_BEAT, 32'd24);
    offer(CMD_TICK, 32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_FRAMES_PER_BEAT, 32'hFFFF_FFFF);
    offer(CMD_TICK, 32'd0);
    offer(CMD_TICK, 32'd178956970);
    offer(CMD_TICK, 32'hFFFF_FFFF);
    wait_idle();
    // Unused sync mode acts as off
    write_reg(REG_SYNC_MODE, SYNC_UNUSED);
    offer(CMD_TICK, 32'd0);
    offer(CMD_REWIND, 32'd0);
    wait_idle();

    // Random chunks, each under its own register setting
    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      if (chunk < 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 62;
      end else if (chunk < 6) begin
        send_idle_pct = 62;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n_items    = 23;
      rewind_pct = 6;
      case (chunk)
        0: begin
          write_reg(REG_SYNC_MODE, SYNC_MTC);
          write_reg(REG_MTC_RATE, $urandom_range(2, 50));
          write_reg(REG_MTC_FPS, 32'd24);
        end
        1: begin
          write_reg(REG_SYNC_MODE, SYNC_CLOCK);
          write_reg(REG_FRAMES_PER_BEAT, $urandom_range(24, 2000));
        end
        2: begin
          write_reg(REG_SYNC_MODE, SYNC_MTC);
          write_reg(REG_MTC_RATE, $urandom);
          write_reg(REG_MTC_FPS, 32'd30);
          // Stall the receiver long enough for the input to back up
          long_hold_req = 1'b1;
        end
        3: begin
          // One frame per second and a burst per tick: run the seconds past their wrap
          write_reg(REG_MTC_RATE, 32'd0);
          write_reg(REG_MTC_FPS, 32'd1);
          n_items    = 75;
          rewind_pct = 0;
        end
        4: begin
          write_reg(REG_SYNC_MODE, SYNC_CLOCK);
          write_reg(REG_FRAMES_PER_BEAT, $urandom);
        end
        5: begin
          write_reg(REG_SYNC_MODE, SYNC_UNUSED);
          n_items = 10;
        end
        6: begin
          write_reg(REG_SYNC_MODE, SYNC_MTC);
          write_reg(REG_MTC_RATE, $urandom_range(2, 5000));
          write_reg(REG_MTC_FPS, $urandom_range(24, 30));
        end
        7: begin
          write_reg(REG_SYNC_MODE, SYNC_CLOCK);
          write_reg(REG_FRAMES_PER_BEAT, $urandom_range(0, 23));
          n_items = 20;
        end
        default: begin
          write_reg(REG_SYNC_MODE, SYNC_MTC);
          write_reg(REG_MTC_RATE, $urandom_range(2, 1000));
          write_reg(REG_MTC_FPS, $urandom_range(0, 31));
        end
      endcase
      for (int i = 0; i < n_items; i++) offer_random(rewind_pct);
      wait_idle();
    end

    $display("Run took %0d inputs (%0d rewinds) over %0d register writes, checking %0d messages",
             inputs_accepted, rewinds_seen, reg_writes, msgs_checked);
    $display("Predicted %0d clock bytes and %0d quarter-frame bursts", clock_bytes, qf_bursts);
    if (mismatches == 0 && midi_expected.size() == 0) begin
      $display("midi_timecode_and_clock_generator verification clean");
    end else begin
      $display("midi_timecode_and_clock_generator verification failed");
    end
    $finish;
  end

endmodule

// ----- midi_timecode_and_clock_generator.f -----
+incdir+rtl/core
rtl/core/mtcg_pkg.sv
rtl/core/mtcg_div.sv
rtl/core/mtcg_datapath.sv
rtl/core/mtcg_ctrl.sv
rtl/core/midi_timecode_and_clock_generator.sv
rtl/core/mtcg_checker.sv
bench/tb.sv
